[hdl/type_feedback_profile_table_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the type feedback profile table
// Shared forms for concurrent checks, clocked on clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef TYPE_FEEDBACK_PROFILE_TABLE_UNIT_ASSERT_SVH
`define TYPE_FEEDBACK_PROFILE_TABLE_UNIT_ASSERT_SVH

// Check a property on a given clock, disabled while the given reset is low.
`define TFPT_ASSERT_AT(label, ck, rn, prop, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Check a property on clk, disabled while rst_n is low.
`define TFPT_ASSERT(label, prop, msg) \
    `TFPT_ASSERT_AT(label, clk, rst_n, prop, msg)

`endif

[hdl/tfpt_pkg.sv]
// ----------------------------------------------------------------------------
// tfpt_pkg
// Types and constants shared by the type feedback profile table modules.
// ----------------------------------------------------------------------------
package tfpt_pkg;

    localparam int PROFILE_ENTRIES_DEF = 1024;
    localparam int COUNT_BITS_DEF      = 16;

    localparam logic [15:0] THRESHOLD_RESET = 16'd10;
    localparam logic [31:0] TOP_TYPE        = 32'hFFFF_FFFF;
    localparam logic [31:0] INT32_BIT       = 32'h0000_0001;
    localparam logic [31:0] NUMBER_BITS     = 32'h0000_0003;
    localparam logic [15:0] SHOWN_MAX       = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_OBSERVE = 2'd0,
        KIND_QUERY   = 2'd1,
        KIND_CLEAR   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  slot_index;
        logic [31:0] observed_type;
    } in_item_t;

    typedef struct packed {
        logic [31:0] speculated_type;
        logic        likely_int32;
        logic        likely_number;
        logic        is_monomorphic;
        logic [15:0] samples_seen;
    } out_item_t;

endpackage

[hdl/tfpt_store.sv]
// ----------------------------------------------------------------------------
// tfpt_store
// Profile memory: one read port with registered data, one write port, and a
// clearing sweep over every entry after reset.
// ----------------------------------------------------------------------------
module tfpt_store #(
    parameter int ENTRIES = 1024,
    parameter int DATA_W  = 48,
    parameter int ADDR_W  = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    output logic              clear_busy
);
    import tfpt_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRIES - 1);

    logic [DATA_W-1:0] mem_reg [ENTRIES];
    logic [DATA_W-1:0] rd_data_reg;
    logic              clr_busy_reg, clr_busy_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_busy_next = 1'b0;
            end
        end
        // sweep owns the port until it finishes
        mem_we    = clr_busy_reg ? 1'b1 : wr_en;
        mem_waddr = clr_busy_reg ? clr_addr_reg : wr_addr;
        mem_wdata = clr_busy_reg ? '0 : wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_reg[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clr_busy_reg;

endmodule

[hdl/tfpt_update.sv]
// ----------------------------------------------------------------------------
// tfpt_update
// Entry update and speculation view for one transaction.
// ----------------------------------------------------------------------------
module tfpt_update #(
    parameter int COUNT_BITS = 16
) (
    input  tfpt_pkg::in_item_t        item,
    input  logic                      in_range,
    input  logic [32+COUNT_BITS-1:0]  entry_old,
    input  logic [15:0]               threshold,
    output logic                      wr_en,
    output logic [32+COUNT_BITS-1:0]  entry_new,
    output tfpt_pkg::out_item_t       result
);
    import tfpt_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [31:0]           mask_old, mask_new, mask_shown, spec;
    logic [COUNT_BITS-1:0] count_old, count_new, count_shown;
    logic [31:0]           count_wide;

    always_comb
    begin
        mask_old  = entry_old[32+COUNT_BITS-1:COUNT_BITS];
        count_old = entry_old[COUNT_BITS-1:0];
        mask_new  = mask_old;
        count_new = count_old;
        wr_en     = 1'b0;
        case (kind_t'(item.kind))
            KIND_OBSERVE:
            begin
                mask_new  = mask_old | item.observed_type;
                count_new = (count_old == COUNT_MAX) ? count_old
                                                     : count_old + COUNT_BITS'(1);
                wr_en     = in_range;
            end
            KIND_CLEAR:
            begin
                mask_new  = '0;
                count_new = '0;
                wr_en     = in_range;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
        entry_new = {mask_new, count_new};

        // out-of-range slots answer as an empty entry
        mask_shown  = in_range ? mask_new : '0;
        count_shown = in_range ? count_new : '0;
        count_wide  = 32'(count_shown);

        spec = (count_wide < 32'(threshold)) ? TOP_TYPE : mask_shown;

        result.speculated_type = spec;
        result.likely_int32    = (spec == INT32_BIT);
        result.likely_number   = (spec != '0) && ((spec & ~NUMBER_BITS) == '0);
        result.is_monomorphic  = (mask_shown != '0)
                                 && ((mask_shown & (mask_shown - 32'd1)) == '0);
        result.samples_seen    = (count_wide > 32'(SHOWN_MAX)) ? SHOWN_MAX
                                                               : count_wide[15:0];
    end

endmodule

[hdl/type_feedback_profile_table_unit.sv]
// ----------------------------------------------------------------------------
// type_feedback_profile_table_unit
// Per-slot type profile table: observe, query and clear transactions on a
// read-modify-write memory with write-back forwarding.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Payload
//  -------  ---------  -----------------  ---------------------------------
//  in       sink       in_valid/in_stall  in_data  (kind, slot, type mask)
//  out      source     out_valid/out_stall out_data (speculation view)
//  cfg      sink       cfg_valid/cfg_ready cfg_data (sample_threshold)
//
//  Sustains one transaction per cycle while the output is not stalled; a
//  transaction's memory read is registered at its accepting edge, then the
//  read stage updates, writes back and loads the result into the output
//  register. The single memory read/write port pair sets this.
//  After reset a clearing sweep writes zero to every entry, with in_stall
//  high; configuration writes are taken throughout.
//  A stalled result holds the update stage, which then holds in_stall.
// ----------------------------------------------------------------------------
module type_feedback_profile_table_unit #(
    parameter int PROFILE_ENTRIES = tfpt_pkg::PROFILE_ENTRIES_DEF,
    parameter int COUNT_BITS      = tfpt_pkg::COUNT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tfpt_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output tfpt_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);
    import tfpt_pkg::*;

    localparam int ADDR_W = (PROFILE_ENTRIES > 1) ? $clog2(PROFILE_ENTRIES) : 1;
    localparam int IDX_W  = (ADDR_W > 10) ? ADDR_W : 10;
    localparam int DATA_W = 32 + COUNT_BITS;

    // Configuration register
    logic [15:0] threshold_reg;

    // Read stage: transaction waiting on its memory read data
    logic              s1_valid_reg;
    in_item_t          s1_item_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_range_reg;

    // Last write-back, forwarded when it lands on the entry being read
    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [DATA_W-1:0] fwd_data_reg;

    // Output register
    logic      out_valid_reg;
    out_item_t out_data_reg;

    logic              clear_busy;
    logic              in_accept;
    logic              s1_advance;
    logic [IDX_W-1:0]  slot_ext;
    logic [ADDR_W-1:0] in_addr;
    logic              in_range;
    logic [DATA_W-1:0] rd_data;
    logic [DATA_W-1:0] entry_cur;
    logic              upd_wr_en;
    logic              mem_wr_en;
    logic [DATA_W-1:0] entry_new;
    out_item_t         upd_result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_valid)
        begin
            threshold_reg <= cfg_data;
        end
    end

    // Decode the slot of an incoming transaction
    assign slot_ext = IDX_W'(in_data.slot_index);
    assign in_addr  = slot_ext[ADDR_W-1:0];
    assign in_range = (32'(in_data.slot_index) < 32'(PROFILE_ENTRIES));

    // Advance the read stage whenever the output register is free or draining
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = clear_busy || (s1_valid_reg && !s1_advance);
    assign in_accept  = in_valid && !in_stall;

    tfpt_store #(
        .ENTRIES (PROFILE_ENTRIES),
        .DATA_W  (DATA_W),
        .ADDR_W  (ADDR_W)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (in_accept),
        .rd_addr    (in_addr),
        .rd_data    (rd_data),
        .wr_en      (mem_wr_en),
        .wr_addr    (s1_addr_reg),
        .wr_data    (entry_new),
        .clear_busy (clear_busy)
    );

    // A write at the same edge as the read leaves stale data; take it from
    // the forwarding register instead
    assign entry_cur = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
                       ? fwd_data_reg : rd_data;

    tfpt_update #(
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .item      (s1_item_reg),
        .in_range  (s1_range_reg),
        .entry_old (entry_cur),
        .threshold (threshold_reg),
        .wr_en     (upd_wr_en),
        .entry_new (entry_new),
        .result    (upd_result)
    );

    // Write back only when the transaction leaves the read stage
    assign mem_wr_en = s1_advance && upd_wr_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (mem_wr_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg  <= in_data;
            s1_addr_reg  <= in_addr;
            s1_range_reg <= in_range;
        end
        if (mem_wr_en)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= entry_new;
        end
        if (s1_advance)
        begin
            out_data_reg <= upd_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[hdl/tfpt_checker.sv]
// ----------------------------------------------------------------------------
// tfpt_checker
// Port-level checks on the profile table, bound to the top level.
// ----------------------------------------------------------------------------
`include "type_feedback_profile_table_unit_assert.svh"

module tfpt_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input tfpt_pkg::out_item_t out_data
);
    import tfpt_pkg::*;

    `TFPT_ASSERT(a_out_valid_hold,
        out_valid && out_stall |=> out_valid,
        "out_valid dropped while stalled")

    `TFPT_ASSERT(a_out_data_hold,
        out_valid && out_stall |=> $stable(out_data),
        "out_data changed while stalled")

    `TFPT_ASSERT(a_int32_is_number,
        out_valid && out_data.likely_int32 |-> out_data.likely_number,
        "likely_int32 without likely_number")

    `TFPT_ASSERT(a_empty_no_flags,
        out_valid && (out_data.samples_seen == 16'd0) |->
            !out_data.is_monomorphic && !out_data.likely_int32 && !out_data.likely_number,
        "flags set on an entry with no samples")

    // An accepted transaction passes the read stage and leaves a result in the output register
    `TFPT_ASSERT(a_accept_gives_result,
        in_valid && !in_stall |-> ##2 out_valid,
        "no result after an accepted transaction")

endmodule

bind type_feedback_profile_table_unit tfpt_checker u_tfpt_checker (.*);

[bench/type_feedback_profile_table_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// type_feedback_profile_table_unit_tb
// Self-checking bench for the type profile table. A queue-fed driver sends
// observe, query and clear transactions in bursts while the result side
// stalls on its own pattern. A shadow copy of the table predicts each result
// view, and the monitor checks every result field against the oldest
// prediction. Phases run under several sample thresholds, including both
// extremes.
// ----------------------------------------------------------------------------
module type_feedback_profile_table_unit_tb;

    import tfpt_pkg::*;

    localparam int          ENTRIES     = PROFILE_ENTRIES_DEF;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;
    localparam int          IDLE_LIMIT  = 4000;
    localparam int          PHASE_ITEMS = 232;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    // Transactions waiting for the driver, and predicted result views.
    in_item_t    pending_items[$];
    out_item_t   expected_views[$];

    // Shadow copy of the profile table and its threshold.
    logic [31:0] shadow_union[ENTRIES];
    logic [15:0] shadow_tally[ENTRIES];
    logic [15:0] shadow_threshold;

    int          burst_left  = 0;
    int          gap_left    = 0;
    int          stall_mode  = 0;
    int          stall_timer = 0;
    int          idle_cycles = 0;
    int          fail_count  = 0;
    int          sent_count  = 0;
    int          checked_count = 0;
    int          threshold_writes = 0;

    // Slots that take most of the random traffic, so counts climb past thresholds.
    int          hot_slots[8] = '{0, 1, 2, 3, 512, 1021, 1022, 1023};

    type_feedback_profile_table_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one transaction to the shadow table and return the view it answers with.
    function automatic out_item_t predict_view(in_item_t item);
        out_item_t   view;
        logic [31:0] mask;
        logic [15:0] tally;
        int          slot;
        slot = item.slot_index;
        if (item.kind == KIND_OBSERVE)
        begin
            shadow_union[slot] |= item.observed_type;
            // Saturate the count at its top value.
            if (shadow_tally[slot] != SHOWN_MAX)
                shadow_tally[slot] += 16'd1;
        end
        else if (item.kind == KIND_CLEAR)
        begin
            shadow_union[slot] = '0;
            shadow_tally[slot] = '0;
        end
        // Query and the unused kind leave the entry alone.
        mask  = shadow_union[slot];
        tally = shadow_tally[slot];
        view.speculated_type = (tally < shadow_threshold) ? TOP_TYPE : mask;
        view.likely_int32    = (view.speculated_type == INT32_BIT);
        view.likely_number   = (view.speculated_type != '0) &&
                               ((view.speculated_type & ~NUMBER_BITS) == '0);
        view.is_monomorphic  = ($countones(mask) == 1);
        view.samples_seen    = tally;
        return view;
    endfunction

    function automatic in_item_t random_item();
        in_item_t    item;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            item.kind = KIND_OBSERVE;
        else if (pick < 80)
            item.kind = KIND_QUERY;
        else if (pick < 92)
            item.kind = KIND_CLEAR;
        else
            item.kind = KIND_UNUSED;
        if ($urandom_range(0, 99) < 70)
            item.slot_index = 10'(hot_slots[$urandom_range(0, 7)]);
        else
            item.slot_index = 10'($urandom_range(0, ENTRIES - 1));
        pick = $urandom_range(0, 99);
        if (pick < 40)
            item.observed_type = 32'($urandom_range(1, 3));
        else if (pick < 55)
            item.observed_type = 32'h1 << $urandom_range(0, 31);
        else if (pick < 65)
            item.observed_type = '0;
        else if (pick < 72)
            item.observed_type = TOP_TYPE;
        else
            item.observed_type = $urandom;
        return item;
    endfunction

    task automatic push_item(logic [1:0] kind, int slot, logic [31:0] mask);
        in_item_t item;
        item.kind          = kind;
        item.slot_index    = 10'(slot);
        item.observed_type = mask;
        pending_items.push_back(item);
    endtask

    task automatic push_random(int count);
        repeat (count)
            pending_items.push_back(random_item());
    endtask

    // Hold until the driver is empty and every predicted result is back,
    // then let the pipeline settle.
    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_views.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_threshold = value;
        threshold_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: pop pending transactions in bursts of random length with random
    // gaps. Hold the payload while the block stalls. Predict at acceptance,
    // so the predictor sees transactions in the order the block takes them.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_views.push_back(predict_view(in_data));
                sent_count++;
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_items.size() != 0)
                begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        // Start a new burst; a third of the time with no gap at all.
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result-side stall: switch among free flow, light random, heavy random
    // and alternating patterns, each held for a random span.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_mode  <= 0;
            stall_timer <= 0;
        end
        else
        begin
            if (stall_timer == 0)
            begin
                stall_mode  <= $urandom_range(0, 3);
                stall_timer <= $urandom_range(32, 256);
            end
            else
                stall_timer <= stall_timer - 1;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 25);
                2: out_stall <= ($urandom_range(0, 99) < 70);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_views.size() == 0)
            begin
                $error("result with no transaction outstanding: %h", out_data);
                fail_count++;
            end
            else
            begin
                out_item_t want;
                want = expected_views.pop_front();
                checked_count++;
                if (out_data.speculated_type !== want.speculated_type)
                begin
                    $error("speculated_type: expected %h, actual %h",
                           want.speculated_type, out_data.speculated_type);
                    fail_count++;
                end
                if (out_data.likely_int32 !== want.likely_int32)
                begin
                    $error("likely_int32: expected %b, actual %b",
                           want.likely_int32, out_data.likely_int32);
                    fail_count++;
                end
                if (out_data.likely_number !== want.likely_number)
                begin
                    $error("likely_number: expected %b, actual %b",
                           want.likely_number, out_data.likely_number);
                    fail_count++;
                end
                if (out_data.is_monomorphic !== want.is_monomorphic)
                begin
                    $error("is_monomorphic: expected %b, actual %b",
                           want.is_monomorphic, out_data.is_monomorphic);
                    fail_count++;
                end
                if (out_data.samples_seen !== want.samples_seen)
                begin
                    $error("samples_seen: expected %0d, actual %0d",
                           want.samples_seen, out_data.samples_seen);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles with no transaction on any channel. The limit
    // covers the clearing sweep after reset and the longest stall pattern.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: directed items, then random phases under several thresholds,
    // ending at the top threshold. Reconfigure only with the pipeline drained.
    // ------------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_union[i] = '0;
            shadow_tally[i] = '0;
        end
        shadow_threshold = THRESHOLD_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset threshold: empty entry, unused kind, all-ones mask, the
        // count crossing the threshold, and clears.
        push_item(KIND_QUERY, 0, TOP_TYPE);
        push_item(KIND_UNUSED, 0, TOP_TYPE);
        push_item(KIND_OBSERVE, ENTRIES - 1, TOP_TYPE);
        repeat (10)
            push_item(KIND_OBSERVE, 0, INT32_BIT);
        push_item(KIND_QUERY, 0, '0);
        push_item(KIND_OBSERVE, 0, 32'h2);
        push_item(KIND_CLEAR, 0, TOP_TYPE);
        push_item(KIND_QUERY, 0, '0);
        push_item(KIND_QUERY, ENTRIES - 1, '0);
        push_item(KIND_CLEAR, ENTRIES - 1, '0);
        wait_drained();

        // Zero threshold: an empty entry shows mask 0 and no flags.
        write_threshold(16'd0);
        push_item(KIND_QUERY, 5, '0);
        push_item(KIND_OBSERVE, 6, '0);
        push_item(KIND_OBSERVE, 7, 32'h2);
        push_item(KIND_OBSERVE, 8, 32'h8000_0000);
        push_item(KIND_OBSERVE, 9, 32'h5);
        push_item(KIND_UNUSED, 7, '0);
        wait_drained();

        // Random phases; the first runs at the reset value again.
        write_threshold(THRESHOLD_RESET);
        push_random(PHASE_ITEMS);
        wait_drained();
        write_threshold(16'd0);
        push_random(PHASE_ITEMS);
        wait_drained();
        write_threshold(16'd1);
        push_random(PHASE_ITEMS);
        wait_drained();
        write_threshold(16'($urandom_range(2, 16)));
        push_random(PHASE_ITEMS);
        wait_drained();
        write_threshold(16'($urandom_range(0, 65535)));
        push_random(PHASE_ITEMS);
        wait_drained();
        write_threshold(16'd3);
        push_random(PHASE_ITEMS);
        wait_drained();

        // Top threshold: every entry stays below it and answers Top.
        write_threshold(SHOWN_MAX);
        push_random(PHASE_ITEMS);
        wait_drained();

        $display("sent %0d transactions, checked %0d results", sent_count, checked_count);
        $display("%0d threshold writes between 0 and 65535, on hot and random slots",
                 threshold_writes);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
